// ===== src/tkst_pkg.sv =====
`timescale 1ns / 1ps

package tkst_pkg;

	localparam int TAG_W   = 24;
	localparam int SCORE_W = 7;
	localparam int RANK_W  = 4;
	localparam int FILL_W  = 4;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_READ   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [TAG_W-1:0]    player_tag;
		logic [SCORE_W-1:0]  new_score;
		logic [RANK_W-1:0]   read_rank;
	} req_t;

	typedef struct packed {
		logic                accepted;
		logic                entry_valid;
		logic [TAG_W-1:0]    entry_tag;
		logic [SCORE_W-1:0]  entry_score;
		logic [FILL_W-1:0]   fill_count;
	} rsp_t;

	typedef struct packed {
		logic [SCORE_W-1:0]  score;
		logic [TAG_W-1:0]    tag;
	} entry_t;

	// Control that the top level hands to every cell of the chain.
	typedef struct packed {
		logic                load;
		logic                occupied;
	} cell_ctrl_t;

endpackage

// ===== src/tkst_cell.sv =====
`timescale 1ns / 1ps

module tkst_cell
	import tkst_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     new_entry,
	input  logic       prev_ge,
	input  entry_t     prev_entry,
	output logic       ge,
	output entry_t     entry
);

	entry_t entry_q;

	// An occupied cell whose score is not below the new one keeps its place, which
	// also keeps equal scores in the order they arrived.
	assign ge    = ctrl.occupied && (entry_q.score >= new_entry.score);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.load && !ge) begin
			if (prev_ge) begin
				entry_q <= new_entry;
			end else begin
				entry_q <= prev_entry;
			end
		end
	end

endmodule

// ===== src/top_k_score_table.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid, req_stall   | req_t: kind, player_tag, new_score, read_rank
// rsp     | out       | rsp_valid, rsp_stall   | rsp_t: accepted, entry_valid, entry_tag,
//         |           |                        |        entry_score, fill_count
//
// All cells of the chain compare against the new score at once and shift in the same edge,
// so one request is taken per cycle while req_stall is low.
// The response appears in the cycle after the request, held in an output register.
// Reset empties the table at once; no clearing pass is needed.
// A stalled response stalls the next request only while the output register is full.

module top_k_score_table
	import tkst_pkg::*;
#(
	parameter int TABLE_DEPTH = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  logic req_valid,
	output logic req_stall,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_next;

	logic             req_fire;
	logic             full;
	logic             insert_ok;
	entry_t           new_entry;
	entry_t           cell_entry [TABLE_DEPTH];
	logic             cell_ge    [TABLE_DEPTH];
	cell_ctrl_t       cell_ctrl  [TABLE_DEPTH];
	entry_t           read_entry;
	logic [CMPW-1:0]  rank_w;
	logic [CMPW-1:0]  count_w;
	logic [CMPW-1:0]  count_next_w;

	assign req_fire  = req_valid && !req_stall;
	assign req_stall = rsp_valid_q && rsp_stall;

	assign new_entry.score = req.new_score;
	assign new_entry.tag   = req.player_tag;

	// When full, only a score strictly above the lowest one gets in; the lowest entry
	// then falls off the end of the chain.
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign insert_ok = !full || (req.new_score > cell_entry[TABLE_DEPTH-1].score);

	genvar g;
	generate
		for (g = 0; g < TABLE_DEPTH; g++) begin : gen_cell
			assign cell_ctrl[g].load     = req_fire && (req.kind == KIND_INSERT) && insert_ok;
			assign cell_ctrl[g].occupied = (CW'(g) < count_q);

			if (g == 0) begin : gen_head
				tkst_cell u_cell (
					.clk        (clk),
					.ctrl       (cell_ctrl[g]),
					.new_entry  (new_entry),
					.prev_ge    (1'b1),
					.prev_entry (new_entry),
					.ge         (cell_ge[g]),
					.entry      (cell_entry[g])
				);
			end else begin : gen_body
				tkst_cell u_cell (
					.clk        (clk),
					.ctrl       (cell_ctrl[g]),
					.new_entry  (new_entry),
					.prev_ge    (cell_ge[g-1]),
					.prev_entry (cell_entry[g-1]),
					.ge         (cell_ge[g]),
					.entry      (cell_entry[g])
				);
			end
		end
	endgenerate

	assign rank_w  = CMPW'(req.read_rank);
	assign count_w = CMPW'(count_q);

	always_comb begin
		read_entry = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (rank_w == CMPW'(i)) begin
				read_entry = cell_entry[i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (req.kind == KIND_INSERT && insert_ok && !full) begin
			count_next = count_q + CW'(1);
		end
	end

	assign count_next_w = CMPW'(count_next);

	always_comb begin
		rsp_next             = '0;
		rsp_next.fill_count  = count_next_w[FILL_W-1:0];
		if (req.kind == KIND_INSERT) begin
			rsp_next.accepted = insert_ok;
		end else if (rank_w < count_w) begin
			rsp_next.entry_valid = 1'b1;
			rsp_next.entry_tag   = read_entry.tag;
			rsp_next.entry_score = read_entry.score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_fire) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_reject_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.kind == KIND_INSERT) && !insert_ok |=> count_q == $past(count_q))
		else $error("rejected insert changed the count");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.kind == KIND_INSERT) && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("insert into a table with room did not grow it");

	a_read_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req.kind == KIND_READ) |=> count_q == $past(count_q))
		else $error("read changed the count");

	generate
		for (g = 1; g < TABLE_DEPTH; g++) begin : gen_order_chk
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				cell_ctrl[g].occupied |-> cell_entry[g-1].score >= cell_entry[g].score)
				else $error("held entries out of score order");
		end
	endgenerate

endmodule

// ===== dv/top_k_score_table_tb.sv =====
`timescale 1ns / 1ps

module top_k_score_table_tb;
	import tkst_pkg::*;

	localparam int DEPTH      = 10;
	localparam int RAND_ITEMS = 500;
	localparam int HOLD_LEN   = 40;

	// Tracks the ranked table the block should hold and the responses still owed.
	class score_table_sb;
		logic [SCORE_W-1:0] scores [DEPTH];
		logic [TAG_W-1:0]   tags [DEPTH];
		int                 held;
		rsp_t               owed_q[$];
		int                 errors;

		function new();
			held   = 0;
			errors = 0;
			for (int i = 0; i < DEPTH; i++) begin
				scores[i] = '0;
				tags[i]   = '0;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function int lowest_score();
			if (held < DEPTH)
				return 0;
			return int'(scores[DEPTH-1]);
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			int   pos;
			int   i;
			e = '0;
			if (r.kind == KIND_INSERT) begin
				if (held >= DEPTH && r.new_score <= scores[DEPTH-1]) begin
					e.accepted = 1'b0;
				end else begin
					// A full table gives up its lowest entry to the newcomer.
					if (held >= DEPTH)
						held = DEPTH - 1;
					pos = 0;
					while (pos < held && scores[pos] >= r.new_score)
						pos++;
					for (i = held; i > pos; i--) begin
						scores[i] = scores[i-1];
						tags[i]   = tags[i-1];
					end
					scores[pos] = r.new_score;
					tags[pos]   = r.player_tag;
					held++;
					e.accepted = 1'b1;
				end
			end else if (int'(r.read_rank) < held) begin
				e.entry_valid = 1'b1;
				e.entry_tag   = tags[r.read_rank];
				e.entry_score = scores[r.read_rank];
			end
			e.fill_count = FILL_W'(held);
			owed_q.push_back(e);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (owed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected response %h", got));
				return;
			end
			want = owed_q.pop_front();
			if (got.accepted !== want.accepted)
				report_mismatch($sformatf("accepted %b, want %b", got.accepted, want.accepted));
			if (got.entry_valid !== want.entry_valid)
				report_mismatch($sformatf("entry_valid %b, want %b",
					got.entry_valid, want.entry_valid));
			if (got.entry_tag !== want.entry_tag)
				report_mismatch($sformatf("entry_tag %h, want %h", got.entry_tag, want.entry_tag));
			if (got.entry_score !== want.entry_score)
				report_mismatch($sformatf("entry_score %0d, want %0d",
					got.entry_score, want.entry_score));
			if (got.fill_count !== want.fill_count)
				report_mismatch($sformatf("fill_count %0d, want %0d",
					got.fill_count, want.fill_count));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	req_t req = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall = 1'b0;

	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	score_table_sb sb = new();

	top_k_score_table #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("top_k_score_table_tb: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	// Response side: random stall bursts, one long hold-off on request.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	function automatic req_t insert_req(logic [TAG_W-1:0] tag, logic [SCORE_W-1:0] score);
		req_t r;
		r            = '0;
		r.kind       = KIND_INSERT;
		r.player_tag = tag;
		r.new_score  = score;
		r.read_rank  = RANK_W'($urandom);
		return r;
	endfunction

	function automatic req_t read_req(logic [RANK_W-1:0] rank);
		req_t r;
		r            = '0;
		r.kind       = KIND_READ;
		r.player_tag = TAG_W'($urandom);
		r.new_score  = SCORE_W'($urandom);
		r.read_rank  = rank;
		return r;
	endfunction

	// Most inserts land close to the current lowest score so that a full table keeps
	// seeing ties, rejections and replacements rather than settling.
	function automatic req_t random_req();
		int s;
		if ($urandom_range(0, 9) < 4) begin
			if ($urandom_range(0, 3) == 0)
				return read_req(RANK_W'($urandom_range(0, 15)));
			return read_req(RANK_W'($urandom_range(0, DEPTH)));
		end
		if ($urandom_range(0, 3) == 0) begin
			s = $urandom_range(0, 127);
		end else begin
			s = sb.lowest_score() + $urandom_range(0, 3) - 1;
			if (s < 0)
				s = 0;
			if (s > 127)
				s = 127;
		end
		return insert_req(TAG_W'($urandom), SCORE_W'(s));
	endfunction

	task send_request(req_t r);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task wait_all_answered();
		req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task run_directed();
		send_request(read_req(4'd0));
		send_request(read_req(4'd15));
		send_request(insert_req(24'h000000, 7'd0));
		send_request(insert_req(24'hFFFFFF, 7'd127));
		send_request(insert_req(24'hAAAAAA, 7'd64));
		// Equal scores must stay in the order they arrived.
		send_request(insert_req(24'h555555, 7'd64));
		send_request(insert_req(24'h414243, 7'd64));
		send_request(read_req(4'd2));
		send_request(read_req(4'd3));
		send_request(insert_req(TAG_W'($urandom), 7'd10));
		send_request(insert_req(TAG_W'($urandom), 7'd20));
		send_request(insert_req(TAG_W'($urandom), 7'd30));
		send_request(insert_req(TAG_W'($urandom), 7'd40));
		send_request(insert_req(TAG_W'($urandom), 7'd5));
		send_request(read_req(4'd9));
		send_request(read_req(4'd10));
		// Full table: equal to the lowest is turned away, one above it replaces it.
		send_request(insert_req(24'h123456, 7'd0));
		send_request(insert_req(24'h654321, 7'd1));
		send_request(insert_req(24'h0F0F0F, 7'd1));
		send_request(insert_req(24'hF0F0F0, 7'd127));
		send_request(read_req(4'd0));
		send_request(read_req(4'd1));
		send_request(read_req(4'd9));
		send_request(read_req(4'd15));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_all_answered();
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == 120)
				long_hold = 1'b1;
			if (n == 250)
				wait_all_answered();
			if (n == RAND_ITEMS - 100)
				quiet = 1'b1;
			send_request(random_req());
		end
		wait_all_answered();
		repeat (8) @(posedge clk);
		if (sb.errors == 0)
			$display("top_k_score_table_tb: clean");
		else
			$display("top_k_score_table_tb: errors");
		$finish;
	end

endmodule
